[sv/vprd_pkg.sv]
// Package for the voxel payload run-length decoder.
// Field widths, register indexes, payload codes and the queue item type.
// No dependencies.
package vprd_pkg;

    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 24;
    localparam int RUN_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_ALPHA = 3'd5;

    localparam logic [WORD_W-1:0] CODE_RUN        = 32'd2;
    localparam logic [WORD_W-1:0] CODE_NEXT_SLICE = 32'd6;
    localparam logic [7:0]        ALPHA_FULL      = 8'hFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic color_order;
        logic rle_mode;
        logic binary_alpha;
    } t_mode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              matrix_start;
        logic              is_next;
        logic              is_run;
        t_color            color;
    } t_item;

endpackage

[sv/vprd_if.sv]
// Channel interfaces of the voxel payload run-length decoder.
// Depends on vprd_pkg for field widths.
interface vprd_in_if import vprd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              matrix_start;

    modport source (output valid, output data_word, output matrix_start, input ready);
    modport sink   (input valid, input data_word, input matrix_start, output ready);
endinterface

interface vprd_out_if import vprd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] voxel_index;
    logic [RUN_W-1:0] run_length;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             matrix_done;

    modport source (output valid, output voxel_index, output run_length, output red,
                    output green, output blue, output alpha, output matrix_done,
                    input ready);
    modport sink   (input valid, input voxel_index, input run_length, input red,
                    input green, input blue, input alpha, input matrix_done,
                    output ready);
endinterface

interface vprd_cfg_if import vprd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/vprd_front.sv]
// Front end: takes payload words, flags the slice and run codes, swizzles color and sets binary alpha.
// Depends on vprd_pkg and vprd_in_if.
module vprd_front import vprd_pkg::*; (
    vprd_in_if.sink i_in,
    input  t_mode   i_mode,
    input  logic    i_q_ready,
    output logic    o_push,
    output t_item   o_item
);

    logic [7:0] b0, b1, b2, b3;

    assign b0 = i_in.data_word[7:0];
    assign b1 = i_in.data_word[15:8];
    assign b2 = i_in.data_word[23:16];
    assign b3 = i_in.data_word[31:24];

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        o_item.word         = i_in.data_word;
        o_item.matrix_start = i_in.matrix_start;
        o_item.is_next      = (i_in.data_word == CODE_NEXT_SLICE);
        o_item.is_run       = (i_in.data_word == CODE_RUN);
        o_item.color.green  = b1;
        if (i_mode.color_order) begin
            o_item.color.red  = b2;
            o_item.color.blue = b0;
        end else begin
            o_item.color.red  = b0;
            o_item.color.blue = b2;
        end
        o_item.color.alpha = (i_mode.binary_alpha && (b3 != 8'd0)) ? ALPHA_FULL : b3;
    end

endmodule

[sv/vprd_queue.sv]
// Short FIFO between front end and decode back end.
// Depends on vprd_pkg for the item type and depth.
module vprd_queue import vprd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/vprd_back.sv]
// Decode back end: slice bookkeeping, run clipping and the output register.
// Depends on vprd_pkg and vprd_out_if.
module vprd_back import vprd_pkg::*; #(
    parameter int MAX_DIM = 256,
    localparam int ESZ_W  = $clog2(MAX_DIM + 1),
    localparam int AREA_W = $clog2(MAX_DIM * MAX_DIM + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_item                i_item,
    output logic                 o_pop,
    input  logic                 i_rle_mode,
    input  logic [AREA_W-1:0]    i_area,
    input  logic [ESZ_W-1:0]     i_eff_z,
    vprd_out_if.source           o_out
);

    localparam int ZC_W   = ((ESZ_W > SIZE_W) ? ESZ_W : SIZE_W) + 1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_COLOR = 2'd2
    } t_phase;

    t_phase              r_phase, n_phase, e_phase;
    logic [SIZE_W-1:0]   r_sn, n_sn, e_sn;
    logic [AREA_W-1:0]   r_pos, n_pos, e_pos;
    logic [IDX_W-1:0]    r_base, n_base, e_base;
    logic [AREA_W-1:0]   r_pend, n_pend, e_pend;
    logic                r_fin, n_fin, e_fin;

    logic                r_valid;
    logic [IDX_W-1:0]    r_index;
    logic [RUN_W-1:0]    r_run;
    t_color              r_color;
    logic                r_done;

    logic [AREA_W-1:0]   left, pos1, pend_c, len;
    logic [SIZE_W-1:0]   ns_sn;
    logic [IDX_W-1:0]    ns_base, start_idx;
    logic                ns_fin, done;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    // matrix_start wipes the decode state before this word is handled
    always_comb begin
        if (i_item.matrix_start) begin
            e_phase = PH_IDLE;
            e_sn    = '0;
            e_pos   = '0;
            e_base  = '0;
            e_pend  = '0;
            e_fin   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_sn    = r_sn;
            e_pos   = r_pos;
            e_base  = r_base;
            e_pend  = r_pend;
            e_fin   = r_fin;
        end
    end

    assign left      = (e_pos < i_area) ? i_area - e_pos : '0;
    assign pos1      = e_pos + AREA_W'(1);
    assign pend_c    = (e_pend > left) ? left : e_pend;
    assign ns_sn     = e_sn + SIZE_W'(1);
    assign ns_base   = e_base + IDX_W'(i_area);
    assign ns_fin    = (ZC_W'(e_sn) + ZC_W'(1)) >= ZC_W'(i_eff_z);
    assign start_idx = e_base + IDX_W'(e_pos);

    always_comb begin
        n_phase = e_phase;
        n_sn    = e_sn;
        n_pos   = e_pos;
        n_base  = e_base;
        n_pend  = e_pend;
        n_fin   = e_fin;
        len     = '0;
        done    = 1'b0;
        if (!e_fin) begin
            if (!i_rle_mode) begin
                if (left != '0) begin
                    len   = AREA_W'(1);
                    n_pos = pos1;
                    if (pos1 >= i_area) begin
                        n_sn   = ns_sn;
                        n_base = ns_base;
                        n_pos  = '0;
                        n_fin  = ns_fin;
                        done   = ns_fin;
                    end
                end
            end else begin
                unique case (e_phase)
                    PH_COUNT: begin
                        n_pend  = (i_item.word < WORD_W'(left)) ? AREA_W'(i_item.word) : left;
                        n_phase = PH_COLOR;
                    end
                    PH_COLOR: begin
                        len     = pend_c;
                        n_pos   = e_pos + pend_c;
                        n_pend  = '0;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (i_item.is_next) begin
                            n_sn   = ns_sn;
                            n_base = ns_base;
                            n_pos  = '0;
                            n_fin  = ns_fin;
                            done   = ns_fin;
                        end else if (i_item.is_run) begin
                            n_phase = PH_COUNT;
                        end else if (left != '0) begin
                            len   = AREA_W'(1);
                            n_pos = pos1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sn    <= '0;
            r_pos   <= '0;
            r_base  <= '0;
            r_pend  <= '0;
            r_fin   <= 1'b0;
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_sn    <= n_sn;
            r_pos   <= n_pos;
            r_base  <= n_base;
            r_pend  <= n_pend;
            r_fin   <= n_fin;
            r_valid <= 1'b1;
            r_done  <= done;
            r_run   <= RUN_W'(len);
            if (len != '0) begin
                r_index <= start_idx;
                r_color <= i_item.color;
            end else begin
                r_index <= '0;
                r_color <= '0;
            end
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.voxel_index = r_index;
    assign o_out.run_length  = r_run;
    assign o_out.red         = r_color.red;
    assign o_out.green       = r_color.green;
    assign o_out.blue        = r_color.blue;
    assign o_out.alpha       = r_color.alpha;
    assign o_out.matrix_done = r_done;

endmodule

[sv/voxel_payload_rle_decoder.sv]
// Top level of the voxel payload run-length decoder: config registers,
// front end, queue and decode back end. Depends on vprd_pkg, vprd_if and submodules.
//
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   data_word[31:0], matrix_start
//  o_out     out  valid/ready   voxel_index[23:0], run_length[16:0], red..alpha, matrix_done
//  i_cfg     in   valid/ready   index[2:0], data[8:0]  (ready always high)
//
// One word per cycle sustained while the output is not stalled; a word is written to the
// queue when taken and its result loads the back end's output register once it is popped.
// Reset is synchronous, active low; it clears the queue, decode state and sizes to 1.
// A stalled output holds its word; the 2-entry queue takes up to two more words,
// then i_in.ready drops until the output moves.
// Slice area is registered from the size registers in the cycle after a write.
module voxel_payload_rle_decoder import vprd_pkg::*; #(
    parameter int MAX_DIM = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vprd_in_if.sink      i_in,
    vprd_out_if.source   o_out,
    vprd_cfg_if.sink     i_cfg
);

    localparam int ESZ_W  = $clog2(MAX_DIM + 1);
    localparam int AREA_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int CMP_W  = (ESZ_W > SIZE_W) ? ESZ_W : SIZE_W;

    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    t_mode             r_mode;
    logic [AREA_W-1:0] r_area;
    logic [ESZ_W-1:0]  r_eff_z;

    logic              q_ready, q_valid, push, pop;
    t_item             f_item, q_item;

    // 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic logic [ESZ_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [ESZ_W-1:0] res;
        if (v == '0) begin
            res = ESZ_W'(1);
        end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
            res = ESZ_W'(MAX_DIM);
        end else begin
            res = ESZ_W'(v);
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(1);
            r_size_y <= SIZE_W'(1);
            r_size_z <= SIZE_W'(1);
            r_mode   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SIZE_X:       r_size_x            <= i_cfg.data;
                CFG_SIZE_Y:       r_size_y            <= i_cfg.data;
                CFG_SIZE_Z:       r_size_z            <= i_cfg.data;
                CFG_COLOR_ORDER:  r_mode.color_order  <= i_cfg.data[0];
                CFG_RLE_MODE:     r_mode.rle_mode     <= i_cfg.data[0];
                CFG_BINARY_ALPHA: r_mode.binary_alpha <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_area  <= AREA_W'(eff_size(r_size_x)) * AREA_W'(eff_size(r_size_y));
        r_eff_z <= eff_size(r_size_z);
    end

    vprd_front u_front (
        .i_in      (i_in),
        .i_mode    (r_mode),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (f_item)
    );

    vprd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    vprd_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .i_rle_mode (r_mode.rle_mode),
        .i_area     (r_area),
        .i_eff_z    (r_eff_z),
        .o_out      (o_out)
    );

endmodule

[sv/vprd_checker.sv]
// Port-level checks for the voxel payload run-length decoder, bound to the top level.
// Depends on vprd_pkg and voxel_payload_rle_decoder.
module vprd_checker import vprd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [IDX_W-1:0] i_index,
    input logic [RUN_W-1:0] i_run,
    input logic [7:0]       i_red,
    input logic [7:0]       i_green,
    input logic [7:0]       i_blue,
    input logic [7:0]       i_alpha,
    input logic             i_done
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_index) && $stable(i_run) && $stable(i_red)
            && $stable(i_green) && $stable(i_blue) && $stable(i_alpha) && $stable(i_done))
        else $error("result word changed while stalled");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_run == '0) |-> (i_index == '0) && (i_red == '0) && (i_green == '0)
            && (i_blue == '0) && (i_alpha == '0))
        else $error("empty run carries nonzero fields");

    // the last slice closes on a raw voxel or on a slice-end code
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done |-> (i_run == RUN_W'(0)) || (i_run == RUN_W'(1)))
        else $error("matrix done on a multi-voxel run");

endmodule

bind voxel_payload_rle_decoder vprd_checker u_vprd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_index (o_out.voxel_index),
    .i_run   (o_out.run_length),
    .i_red   (o_out.red),
    .i_green (o_out.green),
    .i_blue  (o_out.blue),
    .i_alpha (o_out.alpha),
    .i_done  (o_out.matrix_done)
);

[tb/voxel_payload_rle_decoder_tb.sv]
// Testbench for voxel_payload_rle_decoder: a directed table, then random raw and RLE
// matrices under random idling, each result checked against the table or a built-in decode model.
// Depends on vprd_pkg, vprd_if and the decoder RTL.
module voxel_payload_rle_decoder_tb;
    import vprd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM    = 256;
    localparam int RAND_WORDS = 1800;
    localparam int SETTLE     = 4;
    localparam int LONG_HOLD  = 150;

    typedef enum logic [1:0] {PH_CODE, PH_COUNT, PH_COLOR} t_phase;

    typedef struct packed {
        logic [IDX_W-1:0] voxel_index;
        logic [RUN_W-1:0] run_length;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             matrix_done;
    } t_run;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]    reg_val;
        logic [WORD_W-1:0]    word;
        bit                   mstart;
        bit                   typed;
        t_run                 want;
    } t_row;

    localparam t_run NO_WRITE  = '0;
    localparam t_run DONE_ONLY = t_run'{24'd0, 17'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    vprd_in_if  in_ch ();
    vprd_out_if out_ch ();
    vprd_cfg_if cfg_ch ();

    voxel_payload_rle_decoder #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // decode model: registers and state
    logic [SIZE_W-1:0] cfg_x = SIZE_W'(1), cfg_y = SIZE_W'(1), cfg_z = SIZE_W'(1);
    bit                cfg_bgra = 0, cfg_rle = 0, cfg_bin_alpha = 0;
    t_phase            dec_phase = PH_CODE;
    int unsigned       slice_num = 0, slice_pos = 0, run_pending = 0;
    logic [IDX_W-1:0]  slice_base = '0;
    bit                mat_finished = 0;

    t_run        run_q[$];
    t_row        steps[$];
    int          fail_count = 0;
    int unsigned live_words = 0;
    int          burst_left = 0;
    bit          gappy = 1;
    bit          fresh = 0;
    bit          stall_req = 0;

    logic [CFG_IDX_W-1:0] all_regs[6] = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z,
                                          CFG_COLOR_ORDER, CFG_RLE_MODE, CFG_BINARY_ALPHA};

    function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned slice_area();
        return clamp_dim(cfg_x) * clamp_dim(cfg_y);
    endfunction

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        case (idx)
            CFG_SIZE_X:       cfg_x = val;
            CFG_SIZE_Y:       cfg_y = val;
            CFG_SIZE_Z:       cfg_z = val;
            CFG_COLOR_ORDER:  cfg_bgra = val[0];
            CFG_RLE_MODE:     cfg_rle = val[0];
            CFG_BINARY_ALPHA: cfg_bin_alpha = val[0];
            default: ;
        endcase
    endfunction

    function automatic t_run paint(int unsigned len, logic [WORD_W-1:0] w);
        t_run r;
        int unsigned idx;
        r = '0;
        if (len == 0) return r;
        idx = slice_base + slice_pos;
        r.voxel_index = idx[IDX_W-1:0];
        r.run_length  = len[RUN_W-1:0];
        r.red         = cfg_bgra ? w[23:16] : w[7:0];
        r.green       = w[15:8];
        r.blue        = cfg_bgra ? w[7:0] : w[23:16];
        r.alpha       = (cfg_bin_alpha && w[31:24] != 0) ? ALPHA_FULL : w[31:24];
        return r;
    endfunction

    function automatic bit close_slice(int unsigned area);
        slice_num++;
        slice_base = slice_base + area[IDX_W-1:0];
        slice_pos  = 0;
        if (slice_num >= clamp_dim(cfg_z)) begin
            mat_finished = 1;
            return 1;
        end
        return 0;
    endfunction

    function automatic t_run decode_word(logic [WORD_W-1:0] w, bit ms);
        t_run        r;
        int unsigned area, left;
        bit          done;
        area = slice_area();
        if (ms) begin
            dec_phase    = PH_CODE;
            slice_num    = 0;
            slice_pos    = 0;
            slice_base   = '0;
            run_pending  = 0;
            mat_finished = 0;
        end
        left = (slice_pos < area) ? area - slice_pos : 0;
        r    = '0;
        done = 0;
        if (mat_finished) return r;
        if (!cfg_rle) begin
            // raw: phase is left alone, position past area just stalls
            if (left != 0) begin
                r = paint(1, w);
                slice_pos++;
                if (slice_pos >= area) done = close_slice(area);
            end
        end else if (dec_phase == PH_COUNT) begin
            run_pending = (w < left) ? w : left;
            dec_phase   = PH_COLOR;
        end else if (dec_phase == PH_COLOR) begin
            if (run_pending > left) run_pending = left;
            r = paint(run_pending, w);
            slice_pos  += run_pending;
            run_pending = 0;
            dec_phase   = PH_CODE;
        end else begin
            dec_phase = PH_CODE;
            if (w == CODE_NEXT_SLICE) begin
                done = close_slice(area);
            end else if (w == CODE_RUN) begin
                dec_phase = PH_COUNT;
            end else if (left != 0) begin
                r = paint(1, w);
                slice_pos++;
            end
        end
        r.matrix_done = done;
        return r;
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        t_row s;
        s = '{default: '0};
        s.is_cfg  = 1;
        s.reg_idx = idx;
        s.reg_val = val;
        steps = {steps, s};
    endfunction

    function automatic void row_word(logic [WORD_W-1:0] w, bit ms, bit typed, t_run want);
        t_row s;
        s = '{default: '0};
        s.word   = w;
        s.mstart = ms;
        s.typed  = typed;
        s.want   = want;
        steps = {steps, s};
    endfunction

    function automatic logic [WORD_W-1:0] rand_color();
        logic [WORD_W-1:0] c;
        c = $urandom;
        if ($urandom_range(0, 3) == 0) c[31:24] = 8'h00;
        return c;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_dim();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return SIZE_W'(256);
            2:       return SIZE_W'(511);
            3:       return SIZE_W'($urandom_range(257, 511));
            4:       return SIZE_W'(255);
            default: return SIZE_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (run_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        // area is registered in the cycle after the write
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_word(logic [WORD_W-1:0] w, bit ms, bit typed, t_run want);
        int   gap;
        t_run pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gappy ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.data_word    <= w;
        in_ch.matrix_start <= ms;
        do @(posedge i_clk); while (!in_ch.ready);
        if (ms || !mat_finished) live_words++;
        pred = decode_word(w, ms);
        if (typed) pred = want;
        run_q = {run_q, pred};
    endtask

    // random word with a matrix_start picked from where the decode stands
    task automatic feed(logic [WORD_W-1:0] w);
        bit ms;
        if (fresh) ms = 1;
        else if (mat_finished) ms = ($urandom_range(0, 3) != 0);
        else ms = ($urandom_range(0, 49) == 0);
        fresh = 0;
        send_word(w, ms, 0, NO_WRITE);
    endtask

    task automatic rle_stream(int budget);
        int          n;
        int unsigned area;
        n = 0;
        while (n < budget) begin
            area = slice_area();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    feed(rand_color());
                    n++;
                end
                3, 4, 5: begin
                    feed(CODE_RUN);
                    case ($urandom_range(0, 3))
                        0:       feed($urandom_range(0, area + 1));
                        1:       feed($urandom_range(0, 1));
                        2:       feed($urandom);
                        default: feed($urandom_range(1, 4));
                    endcase
                    feed(rand_color());
                    n += 3;
                end
                6, 7: begin
                    feed(CODE_NEXT_SLICE);
                    n++;
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) feed($urandom);
                    else feed($urandom_range(0, 8));
                    n++;
                end
            endcase
        end
    endtask

    // receiver: random ready patterns, plus one long hold-off on request
    initial begin
        int mode, len;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                @(posedge i_clk);
                if (stall_req) begin
                    out_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    stall_req = 0;
                end else begin
                    case (mode)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= $urandom_range(0, 1);
                        2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_runs
        t_run want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (run_q.size() == 0) begin
                $error("voxel run word with nothing pending: index 0x%0h length %0d",
                       out_ch.voxel_index, out_ch.run_length);
                fail_count++;
            end else begin
                want = run_q.pop_front();
                check_field("voxel_index", want.voxel_index, out_ch.voxel_index);
                check_field("run_length", want.run_length, out_ch.run_length);
                check_field("red", want.red, out_ch.red);
                check_field("green", want.green, out_ch.green);
                check_field("blue", want.blue, out_ch.blue);
                check_field("alpha", want.alpha, out_ch.alpha);
                check_field("matrix_done", want.matrix_done, out_ch.matrix_done);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          phase, budget;
        int unsigned rand_base;
        logic [CFG_IDX_W-1:0] idx;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_word    <= '0;
        in_ch.matrix_start <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_SIZE_X;
        cfg_ch.data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // raw 1x1x1 after reset: each word with matrix_start is a whole matrix
        row_word(32'h44332211, 1, 1, t_run'{24'd0, 17'd1, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1});
        row_word(32'h12345678, 0, 1, NO_WRITE);
        row_word(32'hFFFFFFFF, 1, 1, t_run'{24'd0, 17'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
        row_cfg(CFG_COLOR_ORDER, 9'd1);
        row_cfg(CFG_BINARY_ALPHA, 9'd1);
        row_word(32'h01AABBCC, 1, 1, t_run'{24'd0, 17'd1, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 1'b1});
        row_word(32'h00123456, 1, 1, t_run'{24'd0, 17'd1, 8'h12, 8'h34, 8'h56, 8'h00, 1'b1});
        // RLE, size 0 acts as 1 and 511 as 256: area 256, two slices
        row_cfg(CFG_RLE_MODE, 9'd1);
        row_cfg(CFG_SIZE_X, 9'd0);
        row_cfg(CFG_SIZE_Y, 9'd511);
        row_cfg(CFG_SIZE_Z, 9'd2);
        row_cfg(CFG_COLOR_ORDER, 9'd0);
        row_cfg(CFG_BINARY_ALPHA, 9'd0);
        row_word(CODE_RUN, 1, 1, NO_WRITE);
        row_word(32'hFFFFFFFF, 0, 1, NO_WRITE);
        row_word(32'h80706050, 0, 1, t_run'{24'd0, 17'd256, 8'h50, 8'h60, 8'h70, 8'h80, 1'b0});
        row_word(32'h12345678, 0, 1, NO_WRITE);        // literal with the slice full
        row_word(CODE_RUN, 0, 1, NO_WRITE);
        row_word(32'd5, 0, 1, NO_WRITE);
        row_word(32'h11223344, 0, 1, NO_WRITE);        // run clipped to nothing
        row_word(CODE_NEXT_SLICE, 0, 1, NO_WRITE);
        row_word(32'd3, 0, 1, t_run'{24'd256, 17'd1, 8'h03, 8'h00, 8'h00, 8'h00, 1'b0});
        row_word(CODE_NEXT_SLICE, 0, 1, DONE_ONLY);
        // full-size matrix, mode flipped between count and color, depth lowered
        row_cfg(CFG_SIZE_X, 9'd256);
        row_cfg(CFG_SIZE_Y, 9'd256);
        row_cfg(CFG_SIZE_Z, 9'd256);
        row_word(CODE_RUN, 1, 0, NO_WRITE);
        row_word(32'h00010000, 0, 0, NO_WRITE);
        row_cfg(CFG_RLE_MODE, 9'd0);
        row_word(32'hA1B2C3D4, 0, 0, NO_WRITE);
        row_cfg(CFG_RLE_MODE, 9'd1);
        row_word(32'h00000055, 0, 0, NO_WRITE);
        row_cfg(CFG_SIZE_Z, 9'd1);
        row_word(CODE_NEXT_SLICE, 0, 1, DONE_ONLY);
        // raw position beyond a shrunken area
        row_cfg(CFG_RLE_MODE, 9'd0);
        row_cfg(CFG_SIZE_X, 9'd4);
        row_cfg(CFG_SIZE_Y, 9'd1);
        row_cfg(CFG_SIZE_Z, 9'd2);
        row_word(32'hDEADBEEF, 1, 0, NO_WRITE);
        row_word(32'h00000000, 0, 0, NO_WRITE);
        row_word(32'h7F7F7F7F, 0, 0, NO_WRITE);
        row_cfg(CFG_SIZE_X, 9'd2);
        row_word(32'h0BADF00D, 0, 1, NO_WRITE);
        row_word(32'h80000001, 1, 0, NO_WRITE);

        foreach (steps[k]) begin
            if (steps[k].is_cfg) write_reg(steps[k].reg_idx, steps[k].reg_val);
            else send_word(steps[k].word, steps[k].mstart, steps[k].typed, steps[k].want);
        end

        rand_base = live_words;
        phase = 0;
        while (live_words - rand_base < RAND_WORDS) begin
            if ($urandom_range(0, 3) != 0) begin
                foreach (all_regs[k]) begin
                    idx = all_regs[k];
                    write_reg(idx, (k < 3) ? rand_dim() : SIZE_W'($urandom_range(0, 511)));
                end
            end else begin
                idx = all_regs[$urandom_range(0, 5)];
                write_reg(idx, (idx == CFG_SIZE_X || idx == CFG_SIZE_Y || idx == CFG_SIZE_Z) ?
                          rand_dim() : SIZE_W'($urandom_range(0, 511)));
            end
            wait_drained();
            gappy  = ($urandom_range(0, 2) != 0);
            fresh  = ($urandom_range(0, 7) != 0);
            budget = $urandom_range(30, 90);
            if (phase == 3) begin
                // output held off while words keep coming
                gappy     = 0;
                stall_req = 1;
            end
            if (cfg_rle) begin
                rle_stream(budget);
            end else begin
                repeat (budget) feed(rand_color());
            end
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && run_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
